FILE: rtl/core/kpt_pkg.sv
`timescale 1ns / 1ps
// Package for the keyed presence table: depth, modes, result kinds and structs.
// Used by kpt_cell and keyed_presence_table_with_sweep_core; no dependencies.
package kpt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      MODE_UPDATE_OR_ADD = 4'd0,
      MODE_REMOVE_ID     = 4'd1,
      MODE_REMOVE_INDEX  = 4'd2,
      MODE_CLEAR_MARKS   = 4'd3,
      MODE_SET_MARKS     = 4'd4,
      MODE_SWEEP         = 4'd5,
      MODE_CLEAR_ALL     = 4'd6,
      MODE_READ_INDEX    = 4'd7,
      MODE_LOOKUP_ID     = 4'd8
   } mode_type;

   typedef enum logic [2:0] {
      EV_ADDED     = 3'd0,
      EV_UPDATED   = 3'd1,
      EV_REMOVED   = 3'd2,
      EV_FULL      = 3'd3,
      EV_NOT_FOUND = 3'd4,
      EV_DATA      = 3'd5,
      EV_DONE      = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic [3:0]         mode;
      logic signed [31:0] user_id;
      logic [63:0]        record_data;
      logic [4:0]         entry_index;
   } req_type;

   typedef struct packed {
      logic [2:0]         event_kind;
      logic signed [31:0] out_id;
      logic [63:0]        out_record;
      logic [5:0]         entry_count;
      logic [5:0]         updated_count;
      logic [5:0]         removed_count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [63:0] record;
      logic        mark;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic append;
      logic update;
      logic mark_wr;
      logic mark_val;
   } cell_ctl_type;

endpackage

FILE: rtl/core/keyed_presence_table_with_sweep_core.sv
`timescale 1ns / 1ps
// A single-result transaction is registered into req_ff when accepted, executed in ST_EXEC,
// and its result is registered in rsp_ff. Sweep and clear-all give one removal per cycle,
// then the done result; the next transaction is taken in the cycle its last result is shown.
// Each step is one pass along the row of cells. Reset (synchronous) empties the table.
// Results cannot be stalled. Depends on kpt_pkg and kpt_cell.
module keyed_presence_table_with_sweep_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  kpt_pkg::req_type req_item,
   output logic             rsp_valid,
   output kpt_pkg::rsp_type rsp_item
);

   localparam int DEPTH = kpt_pkg::TABLE_DEPTH;
   localparam int IDX_W = kpt_pkg::IDX_W;
   localparam int CNT_W = kpt_pkg::CNT_W;

   kpt_pkg::state_type state_ff, state_in;
   kpt_pkg::req_type   req_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kpt_pkg::rsp_type   rsp_ff, rsp_in;

   kpt_pkg::entry_type    entries [DEPTH];
   kpt_pkg::cell_ctl_type cell_ctl [DEPTH];
   logic [DEPTH-1:0]      match_vec, unmarked_vec;

   logic             hit, any_unmarked;
   logic [IDX_W-1:0] hit_pos, unmarked_pos, sel_pos;
   logic             do_shift, do_append, do_update, do_mark, mark_val;
   logic             idx_ok;
   kpt_pkg::entry_type sel_entry;
   kpt_pkg::mode_type  mode;

   wire accept = start && !busy;

   assign mode   = kpt_pkg::mode_type'(req_ff.mode);
   assign idx_ok = {{(CNT_W > 5 ? CNT_W - 5 : 0){1'b0}}, req_ff.entry_index} < count_ff;

   // The row of cells; each one hands its entry down when the one below is removed.
   for (genvar g = 0; g < DEPTH; g++) begin : gen_cell
      kpt_pkg::entry_type nxt;
      if (g == DEPTH - 1) begin : gen_end
         assign nxt = entries[g];
      end else begin : gen_mid
         assign nxt = entries[g+1];
      end
      assign match_vec[g] = (CNT_W'(g) < count_ff) &&
                            (entries[g].key == req_ff.user_id);
      assign unmarked_vec[g] = (CNT_W'(g) < count_ff) && !entries[g].mark;
      assign cell_ctl[g].shift    = do_shift && (IDX_W'(g) >= sel_pos);
      assign cell_ctl[g].append   = do_append && (count_ff == CNT_W'(g));
      assign cell_ctl[g].update   = do_update && match_vec[g];
      assign cell_ctl[g].mark_wr  = do_mark;
      assign cell_ctl[g].mark_val = mark_val;
      kpt_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[g]),
         .req_key    (req_ff.user_id),
         .req_record (req_ff.record_data),
         .next_entry (nxt),
         .entry      (entries[g])
      );
   end

   // First match and first unmarked entry; keys are unique among valid entries.
   always_comb begin
      hit_pos      = '0;
      unmarked_pos = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_vec[i]) hit_pos = IDX_W'(i);
         if (unmarked_vec[i]) unmarked_pos = IDX_W'(i);
      end
   end
   assign hit          = |match_vec;
   assign any_unmarked = |unmarked_vec;

   always_comb begin
      unique case (mode)
         kpt_pkg::MODE_REMOVE_INDEX,
         kpt_pkg::MODE_READ_INDEX: sel_pos = IDX_W'(req_ff.entry_index);
         kpt_pkg::MODE_SWEEP:      sel_pos = unmarked_pos;
         kpt_pkg::MODE_CLEAR_ALL:  sel_pos = '0;
         default:                  sel_pos = hit_pos;
      endcase
   end
   assign sel_entry = entries[sel_pos];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kpt_pkg::ST_IDLE: begin
            if (accept) begin
               if (kpt_pkg::mode_type'(req_item.mode) == kpt_pkg::MODE_SWEEP ||
                   kpt_pkg::mode_type'(req_item.mode) == kpt_pkg::MODE_CLEAR_ALL)
                  state_in = kpt_pkg::ST_SWEEP;
               else
                  state_in = kpt_pkg::ST_EXEC;
            end
         end
         kpt_pkg::ST_EXEC: state_in = kpt_pkg::ST_IDLE;
         kpt_pkg::ST_SWEEP: begin
            if (mode == kpt_pkg::MODE_SWEEP ? !any_unmarked : (count_ff == '0))
               state_in = kpt_pkg::ST_IDLE;
         end
         default: state_in = kpt_pkg::ST_IDLE;
      endcase
   end

   // Cell controls and the result of this cycle.
   always_comb begin
      do_shift     = 1'b0;
      do_append    = 1'b0;
      do_update    = 1'b0;
      do_mark      = 1'b0;
      mark_val     = 1'b0;
      count_in     = count_ff;
      rem_in       = rem_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.event_kind = kpt_pkg::EV_DONE;
      rsp_in.last       = 1'b1;
      unique case (state_ff)
         kpt_pkg::ST_IDLE: begin
            rem_in = '0;
         end
         kpt_pkg::ST_EXEC: begin
            rsp_valid_in = 1'b1;
            unique case (mode)
               kpt_pkg::MODE_UPDATE_OR_ADD: begin
                  rsp_in.out_id = req_ff.user_id;
                  if (hit) begin
                     do_update = 1'b1;
                     rsp_in.event_kind = kpt_pkg::EV_UPDATED;
                     rsp_in.out_record = req_ff.record_data;
                  end else if (count_ff >= CNT_W'(DEPTH)) begin
                     rsp_in.event_kind = kpt_pkg::EV_FULL;
                  end else begin
                     do_append = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                     rsp_in.event_kind = kpt_pkg::EV_ADDED;
                     rsp_in.out_record = req_ff.record_data;
                  end
               end
               kpt_pkg::MODE_REMOVE_ID: begin
                  rsp_in.out_id = req_ff.user_id;
                  if (hit) begin
                     do_shift = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                     rsp_in.event_kind = kpt_pkg::EV_REMOVED;
                     rsp_in.out_record = sel_entry.record;
                  end else begin
                     rsp_in.event_kind = kpt_pkg::EV_NOT_FOUND;
                  end
               end
               kpt_pkg::MODE_REMOVE_INDEX: begin
                  if (idx_ok) begin
                     do_shift = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                     rsp_in.event_kind = kpt_pkg::EV_REMOVED;
                     rsp_in.out_id     = sel_entry.key;
                     rsp_in.out_record = sel_entry.record;
                  end else begin
                     rsp_in.event_kind = kpt_pkg::EV_NOT_FOUND;
                  end
               end
               kpt_pkg::MODE_CLEAR_MARKS: do_mark = 1'b1;
               kpt_pkg::MODE_SET_MARKS: begin
                  do_mark  = 1'b1;
                  mark_val = 1'b1;
               end
               kpt_pkg::MODE_READ_INDEX: begin
                  if (idx_ok) begin
                     rsp_in.event_kind = kpt_pkg::EV_DATA;
                     rsp_in.out_id     = sel_entry.key;
                     rsp_in.out_record = sel_entry.record;
                  end else begin
                     rsp_in.event_kind = kpt_pkg::EV_NOT_FOUND;
                  end
               end
               kpt_pkg::MODE_LOOKUP_ID: begin
                  rsp_in.out_id = req_ff.user_id;
                  if (hit) begin
                     rsp_in.event_kind = kpt_pkg::EV_DATA;
                     rsp_in.out_record = sel_entry.record;
                  end else begin
                     rsp_in.event_kind = kpt_pkg::EV_NOT_FOUND;
                  end
               end
               default: ;
            endcase
         end
         kpt_pkg::ST_SWEEP: begin
            rsp_valid_in = 1'b1;
            if (mode == kpt_pkg::MODE_SWEEP ? any_unmarked : (count_ff != '0)) begin
               do_shift = 1'b1;
               count_in = count_ff - CNT_W'(1);
               rem_in   = rem_ff + CNT_W'(1);
               rsp_in.event_kind = kpt_pkg::EV_REMOVED;
               rsp_in.out_id     = sel_entry.key;
               rsp_in.out_record = sel_entry.record;
               rsp_in.last       = 1'b0;
            end else if (mode == kpt_pkg::MODE_SWEEP) begin
               // Everything left is marked, so the kept count is the table size.
               rsp_in.updated_count = 6'(count_ff);
               rsp_in.removed_count = 6'(rem_ff);
            end
         end
         default: ;
      endcase
      rsp_in.entry_count = 6'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kpt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_item;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != kpt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds table depth");
   a_keys_unique : assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("duplicate key among valid entries");
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not occupy the block");
   a_last_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && rsp_in.last) |=> !busy)
      else $error("block still busy after final result");
   a_one_result : assert property (@(posedge clock) disable iff (reset)
      (state_ff == kpt_pkg::ST_EXEC) |=> (rsp_valid && rsp_item.last))
      else $error("single-result transaction gave no final result");
`endif

endmodule

FILE: rtl/core/kpt_cell.sv
`timescale 1ns / 1ps
// One table cell: holds a key, a record and a mark, and can take its neighbour's entry.
// Depends on kpt_pkg.
module kpt_cell (
   input  logic                 clock,
   input  kpt_pkg::cell_ctl_type ctl,
   input  logic [31:0]          req_key,
   input  logic [63:0]          req_record,
   input  kpt_pkg::entry_type   next_entry,
   output kpt_pkg::entry_type   entry
);

   kpt_pkg::entry_type entry_ff;
   kpt_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctl.shift) begin
         entry_in = next_entry;
      end else if (ctl.append) begin
         entry_in.key    = req_key;
         entry_in.record = req_record;
         entry_in.mark   = 1'b1;
      end else if (ctl.update) begin
         entry_in.record = req_record;
         entry_in.mark   = 1'b1;
      end else if (ctl.mark_wr) begin
         entry_in.mark = ctl.mark_val;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: dv/tb_keyed_presence_table_with_sweep_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for keyed_presence_table_with_sweep_core: random and directed
// table transactions checked against a behavioural table model. Depends on kpt_pkg.
module tb_keyed_presence_table_with_sweep_core;

   class table_scoreboard;
      logic [31:0]      keys[$];
      logic [63:0]      recs[$];
      bit               marks[$];
      kpt_pkg::rsp_type pending[$];
      int               errors;

      function void push(kpt_pkg::event_type k, logic [31:0] id, logic [63:0] r,
                         int upd, int rem);
         kpt_pkg::rsp_type x;
         x.event_kind    = k;
         x.out_id        = id;
         x.out_record    = r;
         x.entry_count   = 6'(keys.size());
         x.updated_count = 6'(upd);
         x.removed_count = 6'(rem);
         x.last          = 1'b0;
         pending.push_back(x);
      endfunction

      function int find(logic [31:0] id);
         for (int i = 0; i < keys.size(); i++)
            if (keys[i] == id) return i;
         return -1;
      endfunction

      function void drop(int p);
         keys.delete(p);
         recs.delete(p);
         marks.delete(p);
      endfunction

      // Works out the results of one accepted transaction and updates the table copy.
      function void note_request(kpt_pkg::req_type q);
         int p;
         int upd;
         int rem;
         int i;
         logic [31:0] k;
         logic [63:0] r;
         upd = 0;
         rem = 0;
         case (q.mode)
            kpt_pkg::MODE_UPDATE_OR_ADD: begin
               p = find(q.user_id);
               if (p >= 0) begin
                  recs[p] = q.record_data;
                  marks[p] = 1;
                  push(kpt_pkg::EV_UPDATED, q.user_id, q.record_data, 0, 0);
               end else if (keys.size() >= kpt_pkg::TABLE_DEPTH) begin
                  push(kpt_pkg::EV_FULL, q.user_id, '0, 0, 0);
               end else begin
                  keys.push_back(q.user_id);
                  recs.push_back(q.record_data);
                  marks.push_back(1);
                  push(kpt_pkg::EV_ADDED, q.user_id, q.record_data, 0, 0);
               end
            end
            kpt_pkg::MODE_REMOVE_ID: begin
               p = find(q.user_id);
               if (p >= 0) begin
                  r = recs[p];
                  drop(p);
                  push(kpt_pkg::EV_REMOVED, q.user_id, r, 0, 0);
               end else begin
                  push(kpt_pkg::EV_NOT_FOUND, q.user_id, '0, 0, 0);
               end
            end
            kpt_pkg::MODE_REMOVE_INDEX: begin
               if (q.entry_index < keys.size()) begin
                  k = keys[q.entry_index];
                  r = recs[q.entry_index];
                  drop(q.entry_index);
                  push(kpt_pkg::EV_REMOVED, k, r, 0, 0);
               end else begin
                  push(kpt_pkg::EV_NOT_FOUND, '0, '0, 0, 0);
               end
            end
            kpt_pkg::MODE_CLEAR_MARKS, kpt_pkg::MODE_SET_MARKS: begin
               foreach (marks[j]) marks[j] = (q.mode == kpt_pkg::MODE_SET_MARKS);
               push(kpt_pkg::EV_DONE, '0, '0, 0, 0);
            end
            kpt_pkg::MODE_SWEEP: begin
               i = 0;
               while (i < keys.size()) begin
                  if (marks[i]) begin
                     upd++;
                     i++;
                  end else begin
                     k = keys[i];
                     r = recs[i];
                     drop(i);
                     rem++;
                     push(kpt_pkg::EV_REMOVED, k, r, 0, 0);
                  end
               end
               push(kpt_pkg::EV_DONE, '0, '0, upd, rem);
            end
            kpt_pkg::MODE_CLEAR_ALL: begin
               while (keys.size() > 0) begin
                  k = keys[0];
                  r = recs[0];
                  drop(0);
                  push(kpt_pkg::EV_REMOVED, k, r, 0, 0);
               end
               push(kpt_pkg::EV_DONE, '0, '0, 0, 0);
            end
            kpt_pkg::MODE_READ_INDEX: begin
               if (q.entry_index < keys.size())
                  push(kpt_pkg::EV_DATA, keys[q.entry_index], recs[q.entry_index], 0, 0);
               else
                  push(kpt_pkg::EV_NOT_FOUND, '0, '0, 0, 0);
            end
            kpt_pkg::MODE_LOOKUP_ID: begin
               p = find(q.user_id);
               if (p >= 0) push(kpt_pkg::EV_DATA, q.user_id, recs[p], 0, 0);
               else push(kpt_pkg::EV_NOT_FOUND, q.user_id, '0, 0, 0);
            end
            default: push(kpt_pkg::EV_DONE, '0, '0, 0, 0);
         endcase
         pending[pending.size() - 1].last = 1'b1;
      endfunction

      task check_result(kpt_pkg::rsp_type got);
         kpt_pkg::rsp_type w;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", got));
            return;
         end
         w = pending.pop_front();
         if (got.event_kind !== w.event_kind || got.out_id !== w.out_id ||
             got.out_record !== w.out_record || got.entry_count !== w.entry_count ||
             got.updated_count !== w.updated_count ||
             got.removed_count !== w.removed_count || got.last !== w.last)
            report_mismatch($sformatf("got %p, wanted %p", got, w));
      endtask

      task report_mismatch(string s);
         errors++;
         $display("MISMATCH at %0t: %s", $time, s);
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   kpt_pkg::req_type req_item;
   logic             rsp_valid;
   kpt_pkg::rsp_type rsp_item;
   int               cycles;
   bit               quiet;
   logic [31:0]      key_pool[8];
   table_scoreboard  sb;

   keyed_presence_table_with_sweep_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && rsp_valid) sb.check_result(rsp_item);
   end

   // Drives one transaction and holds it until the block takes it.
   task automatic send(kpt_pkg::mode_type m, logic [31:0] id, logic [63:0] r,
                       logic [4:0] ix);
      kpt_pkg::req_type q;
      q.mode = m;
      q.user_id = id;
      q.record_data = r;
      q.entry_index = ix;
      start <= 1'b1;
      req_item <= q;
      do @(posedge clock); while (busy);
      sb.note_request(q);
      if (!quiet && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(19, 1)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_key();
      if ($urandom_range(4) != 0) return key_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   task automatic random_item();
      int s;
      logic [63:0] r;
      r = {$urandom, $urandom};
      s = $urandom_range(99);
      if (s < 40) send(kpt_pkg::MODE_UPDATE_OR_ADD, pick_key(), r, '0);
      else if (s < 50) send(kpt_pkg::MODE_REMOVE_ID, pick_key(), r, 5'($urandom));
      else if (s < 58) send(kpt_pkg::MODE_REMOVE_INDEX, $urandom, r, 5'($urandom));
      else if (s < 64) send(kpt_pkg::MODE_CLEAR_MARKS, $urandom, r, 5'($urandom));
      else if (s < 67) send(kpt_pkg::MODE_SET_MARKS, $urandom, r, 5'($urandom));
      else if (s < 74) send(kpt_pkg::MODE_SWEEP, $urandom, r, 5'($urandom));
      else if (s < 76) send(kpt_pkg::MODE_CLEAR_ALL, $urandom, r, 5'($urandom));
      else if (s < 84) send(kpt_pkg::MODE_READ_INDEX, $urandom, r, 5'($urandom));
      else if (s < 95) send(kpt_pkg::MODE_LOOKUP_ID, pick_key(), r, 5'($urandom));
      else send(kpt_pkg::mode_type'($urandom_range(15, 9)), $urandom, r, 5'($urandom));
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      sb = new();
      quiet = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-table cases, extremes, every mode but clear-all, then filling to capacity.
      send(kpt_pkg::MODE_READ_INDEX, '0, '0, 5'd0);
      send(kpt_pkg::MODE_REMOVE_INDEX, '0, '0, 5'd31);
      send(kpt_pkg::MODE_LOOKUP_ID, 32'h8000_0000, '0, '0);
      send(kpt_pkg::MODE_SWEEP, '0, '0, '0);
      send(kpt_pkg::MODE_UPDATE_OR_ADD, 32'h8000_0000, '0, '0);
      send(kpt_pkg::MODE_UPDATE_OR_ADD, 32'h7fff_ffff, '1, '0);
      send(kpt_pkg::MODE_UPDATE_OR_ADD, 32'h8000_0000, 64'h0123_4567_89ab_cdef, '0);
      send(kpt_pkg::MODE_LOOKUP_ID, 32'h7fff_ffff, '0, '0);
      send(kpt_pkg::MODE_READ_INDEX, '0, '0, 5'd1);
      send(kpt_pkg::MODE_CLEAR_MARKS, '0, '0, '0);
      send(kpt_pkg::MODE_UPDATE_OR_ADD, 32'hffff_ffff, '1, '0);
      send(kpt_pkg::MODE_SWEEP, '0, '0, '0);
      send(kpt_pkg::MODE_SET_MARKS, '0, '0, '0);
      send(kpt_pkg::MODE_REMOVE_ID, 32'h1234_5678, '0, '0);
      send(kpt_pkg::MODE_REMOVE_ID, 32'hffff_ffff, '0, '0);
      send(kpt_pkg::mode_type'(4'hf), '1, '1, '1);
      for (int i = 0; i < 33; i++)
         send(kpt_pkg::MODE_UPDATE_OR_ADD, 32'(i), {$urandom, $urandom}, '0);
      send(kpt_pkg::MODE_UPDATE_OR_ADD, 32'd99, '1, '0);
      send(kpt_pkg::MODE_READ_INDEX, '0, '0, 5'd31);
      send(kpt_pkg::MODE_REMOVE_INDEX, '0, '0, 5'd31);
      send(kpt_pkg::MODE_REMOVE_INDEX, '0, '0, 5'd0);
      send(kpt_pkg::MODE_CLEAR_MARKS, '0, '0, '0);
      send(kpt_pkg::MODE_SWEEP, '0, '0, '0);
      drain();

      for (int n = 0; n < 255; n++) begin
         if (n == 125) drain();
         if (n >= 215) quiet = 1;
         random_item();
      end
      drain();
      if (sb.errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
